// ===== hw/rtl/lstd_pkg.sv =====
// Package for the laser scan obstacle turn decider.
// Holds register indexes, reset values, zone constants and the beam step test.
// No dependencies.
`default_nettype none

package lstd_pkg;

	// widths of the fixed fields
	localparam int RANGE_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// parameter defaults
	localparam int DEF_BEAM_INDEX_BITS = 10;
	localparam int DEF_CENTER_BEAM = 333;

	// zone geometry
	localparam int FLANK_GAP = 50;
	localparam int RIGHT_END = 566;
	localparam int LEFT_START = 100;
	localparam int BEAM_STEP = 5;

	// width of a zone offset, enough for every legal center beam
	localparam int OFS_W = 10;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RIGHT_BASE = 2'd0,
		REG_LEFT_BASE = 2'd1,
		REG_FRONT_LIMIT = 2'd2
	} cfg_reg_t;

	// register reset values
	localparam logic [CFG_W-1:0] RST_RIGHT_BASE = 16'd850;
	localparam logic [CFG_W-1:0] RST_LEFT_BASE = 16'd250;
	localparam logic [CFG_W-1:0] RST_FRONT_LIMIT = 16'd300;

	// true when the offset is a multiple of the beam step
	// quotient by reciprocal multiply (205/1024), exact for offsets below 1024
	function automatic logic on_step(input logic [OFS_W-1:0] ofs);
		logic [OFS_W+8-1:0] prod;
		logic [OFS_W-1:0] quot;
		logic [OFS_W-1:0] back;
		prod = {8'd0, ofs} * (OFS_W+8)'(205);
		quot = OFS_W'(prod[OFS_W+8-1:OFS_W]);
		back = quot * OFS_W'(BEAM_STEP);
		return (ofs == back);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/laser_scan_obstacle_turn_decider_unit.sv =====
// Laser scan obstacle turn decider, top level.
// Depends on lstd_pkg for constants, register indexes and the beam step test.
//
//  channel  | dir | payload
//  ---------+-----+---------------------------------------------------
//  s_axis   | in  | tdata: beam_index, range_mm; tlast: scan_end
//  m_axis   | out | tdata: blocked, turn_left (one per scan)
//  cfg      | in  | cfg_wen, cfg_addr, cfg_wdata (write only)
//
// one sample per cycle, except while a scan end stalls: input register, then
// zone compare and decision into the result register, so a scan end accepted
// into the input register is shown on m_axis once it reaches the result register.
// throughput is set by the single result register: a scan end stalls only
// while the previous result has not been taken.
// reset clears hit marks, decision, valid bits and loads register defaults.
`default_nettype none

module laser_scan_obstacle_turn_decider_unit #(
	parameter int BEAM_INDEX_BITS = lstd_pkg::DEF_BEAM_INDEX_BITS,
	parameter int CENTER_BEAM = lstd_pkg::DEF_CENTER_BEAM,
	localparam int S_TDATA_W = ((BEAM_INDEX_BITS + lstd_pkg::RANGE_W + 7) / 8) * 8
) (
	input wire logic clk,
	input wire logic arst_n,
	// input samples
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [S_TDATA_W-1:0] s_tdata, // beam_index, range_mm, zero fill
	input wire logic s_tlast, // scan_end
	// scan results
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata, // blocked, turn_left, zero fill
	// configuration writes
	input wire logic cfg_wen,
	input wire logic [lstd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input wire logic [lstd_pkg::CFG_W-1:0] cfg_wdata
);
	import lstd_pkg::*;

	localparam int IW = BEAM_INDEX_BITS;
	localparam int CW = 13;
	localparam logic [CW-1:0] R_START = CW'(CENTER_BEAM + FLANK_GAP);
	localparam logic [CW-1:0] R_END = CW'(RIGHT_END);
	localparam logic [CW-1:0] L_START = CW'(LEFT_START);
	localparam logic [CW-1:0] L_END = CW'(CENTER_BEAM - FLANK_GAP);
	localparam logic [CW-1:0] C_BEAM = CW'(CENTER_BEAM);

	// configuration registers
	logic [CFG_W-1:0] right_base_q, left_base_q, front_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_base_q <= RST_RIGHT_BASE;
			left_base_q <= RST_LEFT_BASE;
			front_limit_q <= RST_FRONT_LIMIT;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_addr))
				REG_RIGHT_BASE: right_base_q <= cfg_wdata;
				REG_LEFT_BASE: left_base_q <= cfg_wdata;
				REG_FRONT_LIMIT: front_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	logic valid_s1;
	logic [IW-1:0] idx_s1;
	logic [RANGE_W-1:0] range_s1;
	logic last_s1;
	logic out_free, adv_s1;

	assign out_free = !m_tvalid || m_tready;
	assign adv_s1 = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			idx_s1 <= s_tdata[IW-1:0];
			range_s1 <= s_tdata[IW+RANGE_W-1:IW];
			last_s1 <= s_tlast;
		end
	end

	// zone membership and range compare
	logic [CW-1:0] idx_w;
	logic [OFS_W-1:0] r_ofs, l_ofs;
	logic in_right, in_left, in_front;
	logic [RANGE_W+1:0] r_sum;
	logic [RANGE_W:0] l_thr;
	logic right_now, left_now, front_now;

	always_comb begin
		idx_w = CW'(idx_s1);
		r_ofs = OFS_W'(idx_w - R_START);
		l_ofs = OFS_W'(idx_w - L_START);
		in_right = (idx_w >= R_START) && (idx_w < R_END) && on_step(r_ofs);
		in_left = (idx_w >= L_START) && (idx_w < L_END) && on_step(l_ofs);
		in_front = (idx_w == C_BEAM);
		// range < base - idx, done as range + idx < base to avoid wrap
		r_sum = (RANGE_W+2)'(range_s1) + (RANGE_W+2)'(idx_s1);
		l_thr = (RANGE_W+1)'(left_base_q) + (RANGE_W+1)'(idx_s1);
		right_now = in_right && (r_sum < (RANGE_W+2)'(right_base_q));
		left_now = in_left && ((RANGE_W+1)'(range_s1) < l_thr);
		front_now = in_front && (range_s1 < front_limit_q);
	end

	// hit marks and latched decision
	logic right_hit_q, left_hit_q, front_hit_q;
	logic decision_q, direction_q;
	logic rh, lh, fh;
	logic decision_d, direction_d;

	always_comb begin
		rh = right_hit_q || right_now;
		lh = left_hit_q || left_now;
		fh = front_hit_q || front_now;
		decision_d = decision_q;
		direction_d = direction_q;
		if (rh) begin
			if (!decision_q) begin
				decision_d = 1'b1;
				direction_d = 1'b1;
			end
		end else if (lh || fh) begin
			if (!decision_q) begin
				decision_d = 1'b1;
				direction_d = 1'b0;
			end
		end else begin
			decision_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_hit_q <= 1'b0;
			left_hit_q <= 1'b0;
			front_hit_q <= 1'b0;
			decision_q <= 1'b0;
			direction_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				right_hit_q <= 1'b0;
				left_hit_q <= 1'b0;
				front_hit_q <= 1'b0;
				decision_q <= decision_d;
				direction_q <= direction_d;
			end else begin
				right_hit_q <= rh;
				left_hit_q <= lh;
				front_hit_q <= fh;
			end
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'd0, direction_q, decision_q};

`ifndef SYNTH
	// scan end clears all hit marks
	a_marks_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> !right_hit_q && !left_hit_q && !front_hit_q)
		else $error("hit marks not cleared after scan end");

	// a new result appears only after a scan end transaction left the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result without scan end");

	// direction stays latched while the decision stays active
	a_dir_latched: assert property (@(posedge clk) disable iff (!arst_n)
		decision_q && $past(decision_q) |-> $stable(direction_q))
		else $error("direction changed while blocked");

	// decision changes only with a scan end transaction
	a_decision_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && last_s1) |=> $stable(decision_q) && $stable(direction_q))
		else $error("decision changed without scan end");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_laser_scan_obstacle_turn_decider_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for laser_scan_obstacle_turn_decider_unit: queued laser samples,
// a scan decision predictor and a result checker. Depends on lstd_pkg and the unit's RTL.

module tb_laser_scan_obstacle_turn_decider_unit;
	import lstd_pkg::*;

	localparam int IDX_W = DEF_BEAM_INDEX_BITS;
	localparam int CENTER = DEF_CENTER_BEAM;
	localparam int TDATA_W = ((IDX_W + RANGE_W + 7) / 8) * 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RIGHT_FIRST = CENTER + FLANK_GAP;
	localparam int LEFT_STOP = CENTER - FLANK_GAP;
	localparam int IDLE_PCT = 22;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic [IDX_W-1:0] beam;
		logic [RANGE_W-1:0] range_mm;
		logic scan_end;
	} sample_t;

	typedef struct {
		logic blocked;
		logic turn_left;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// samples waiting to be offered and scan verdicts waiting to come out
	sample_t pending_samples[$];
	verdict_t expected_verdicts[$];

	// predictor copy of registers and scan state
	logic [CFG_W-1:0] right_base = RST_RIGHT_BASE;
	logic [CFG_W-1:0] left_base = RST_LEFT_BASE;
	logic [CFG_W-1:0] front_limit = RST_FRONT_LIMIT;
	bit right_mark, left_mark, front_mark;
	bit obstacle_active, turn_left_latched;

	// run control and bookkeeping
	bit steady = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int samples_taken = 0;
	int scans_checked = 0;
	int blocked_scans = 0;
	int settings_used = 1;
	int quiet_cycles = 0;

	laser_scan_obstacle_turn_decider_unit #(
		.BEAM_INDEX_BITS(IDX_W),
		.CENTER_BEAM(CENTER)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// beam lies in [first, stop) on the step grid
	function automatic bit on_beam_grid(int b, int first, int stop);
		return b >= first && b < stop && ((b - first) % BEAM_STEP) == 0;
	endfunction

	// update hit marks for one sample and, at scan end, the latched decision
	task automatic predict_scan_sample(input sample_t smp);
		int b, r;
		verdict_t v;
		b = smp.beam;
		r = smp.range_mm;
		if (on_beam_grid(b, RIGHT_FIRST, RIGHT_END) && r < int'(right_base) - b)
			right_mark = 1'b1;
		if (on_beam_grid(b, LEFT_START, LEFT_STOP) && r < int'(left_base) + b)
			left_mark = 1'b1;
		if (b == CENTER && r < int'(front_limit))
			front_mark = 1'b1;
		if (smp.scan_end) begin
			if (right_mark) begin
				if (!obstacle_active) begin
					turn_left_latched = 1'b1;
					obstacle_active = 1'b1;
				end
			end else if (left_mark || front_mark) begin
				if (!obstacle_active) begin
					turn_left_latched = 1'b0;
					obstacle_active = 1'b1;
				end
			end else begin
				obstacle_active = 1'b0;
			end
			right_mark = 1'b0;
			left_mark = 1'b0;
			front_mark = 1'b0;
			v.blocked = obstacle_active;
			v.turn_left = turn_left_latched;
			expected_verdicts.push_back(v);
		end
	endtask

	task automatic push_sample(input int b, input int r, input bit last);
		sample_t smp;
		smp.beam = b[IDX_W-1:0];
		smp.range_mm = r[RANGE_W-1:0];
		smp.scan_end = last;
		pending_samples.push_back(smp);
	endtask

	// random sample, mostly aimed at the zones, range mostly near the threshold of its beam
	function automatic sample_t make_sample(bit quiet, bit last);
		sample_t smp;
		int kind, b, t, r;
		kind = $urandom_range(0, 9);
		if (kind <= 2)
			b = RIGHT_FIRST + BEAM_STEP * $urandom_range(0, (RIGHT_END - 1 - RIGHT_FIRST) / BEAM_STEP);
		else if (kind <= 5)
			b = LEFT_START + BEAM_STEP * $urandom_range(0, (LEFT_STOP - 1 - LEFT_START) / BEAM_STEP);
		else if (kind == 6)
			b = CENTER;
		else if (kind == 7)
			b = LEFT_START + BEAM_STEP * $urandom_range(0, 100) + $urandom_range(1, BEAM_STEP - 1);
		else
			b = $urandom_range(0, (1 << IDX_W) - 1);
		b = b % (1 << IDX_W);
		if (on_beam_grid(b, RIGHT_FIRST, RIGHT_END))
			t = int'(right_base) - b;
		else if (on_beam_grid(b, LEFT_START, LEFT_STOP))
			t = int'(left_base) + b;
		else if (b == CENTER)
			t = int'(front_limit);
		else
			t = $urandom_range(0, 65535);
		if (quiet)
			r = t + $urandom_range(0, 15);
		else begin
			case ($urandom_range(0, 5))
				0, 1: r = t - 1 - $urandom_range(0, 15);
				2: r = t + $urandom_range(0, 3);
				3: r = $urandom_range(0, 65535);
				4: r = 0;
				default: r = 65535;
			endcase
		end
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		smp.beam = b[IDX_W-1:0];
		smp.range_mm = r[RANGE_W-1:0];
		smp.scan_end = last;
		return smp;
	endfunction

	// whole scans of random length, some with ranges aimed at or above the thresholds
	task automatic queue_scans(input int n_items);
		int made, len;
		bit quiet;
		made = 0;
		@(negedge clk);
		while (made < n_items) begin
			len = $urandom_range(1, 30);
			quiet = ($urandom_range(0, 99) < 45);
			for (int i = 0; i < len; i++) begin
				pending_samples.push_back(make_sample(quiet, i == len - 1));
				made++;
			end
		end
	endtask

	// wait until every sample is taken and every verdict has come out
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] addr, input int value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value[CFG_W-1:0];
		case (addr)
			REG_RIGHT_BASE: right_base = value[CFG_W-1:0];
			REG_LEFT_BASE: left_base = value[CFG_W-1:0];
			REG_FRONT_LIMIT: front_limit = value[CFG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// new register setting once the block has gone quiet
	task automatic apply_setting(input int rb, input int lb, input int fl);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(REG_RIGHT_BASE, rb);
		write_register(REG_LEFT_BASE, lb);
		write_register(REG_FRONT_LIMIT, fl);
		settings_used++;
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin : drive_samples
		sample_t cur;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cur = pending_samples.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= TDATA_W'({cur.range_mm, cur.beam});
				s_tlast <= cur.scan_end;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// accepted samples feed the predictor
	always @(posedge clk) begin : observe_samples
		sample_t smp;
		if (arst_n && s_tvalid && s_tready) begin
			smp.beam = s_tdata[IDX_W-1:0];
			smp.range_mm = s_tdata[IDX_W +: RANGE_W];
			smp.scan_end = s_tlast;
			predict_scan_sample(smp);
			samples_taken++;
		end
	end

	// result receiver with random backpressure and requested long holds
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// verdict checker
	always @(posedge clk) begin : check_verdicts
		verdict_t exp_v;
		if (arst_n && m_tvalid && m_tready) begin
			scans_checked++;
			if (m_tdata[0])
				blocked_scans++;
			if (expected_verdicts.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected scan verdict blocked=%b turn_left=%b",
						$time, m_tdata[0], m_tdata[1]);
			end else begin
				exp_v = expected_verdicts.pop_front();
				if (m_tdata[0] !== exp_v.blocked || m_tdata[1] !== exp_v.turn_left) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: scan %0d expected blocked=%b turn_left=%b, got blocked=%b turn_left=%b",
							$time, scans_checked, exp_v.blocked, exp_v.turn_left,
							m_tdata[0], m_tdata[1]);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cycles);
				$display("laser_scan_obstacle_turn_decider_unit test failed");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		// directed scans on reset register values
		// right hit sets a left turn
		push_sample(383, 0, 0);
		push_sample(563, 65535, 1);
		// left hit while active keeps the latched direction
		push_sample(100, 349, 0);
		push_sample(333, 300, 1);
		// only off-grid, out-of-zone or at-threshold beams: decision clears
		push_sample(280, 530, 0);
		push_sample(281, 0, 0);
		push_sample(283, 0, 0);
		push_sample(99, 0, 0);
		push_sample(568, 0, 0);
		push_sample(382, 0, 0);
		push_sample(1023, 0, 1);
		// front hit on the last sample itself
		push_sample(333, 299, 1);
		// right hit while already active keeps turning right
		push_sample(333, 0, 0);
		push_sample(563, 286, 0);
		push_sample(0, 0, 1);
		// repeated beam, mark stays set
		push_sample(100, 65535, 0);
		push_sample(100, 0, 0);
		push_sample(500, 65535, 1);
		// clear, then right hit on the last sample
		push_sample(512, 65535, 1);
		push_sample(563, 286, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// defaults, with a long receiver hold while samples keep coming
		queue_scans(180);
		hold_requests++;

		// wide thresholds, no idling at all
		apply_setting(65535, 0, 65535);
		steady = 1'b1;
		queue_scans(180);
		wait_drained();
		steady = 1'b0;

		// right threshold always negative, left sum past 16 bits
		apply_setting(0, 65535, 0);
		queue_scans(180);

		// random thresholds and a write to the unused index
		apply_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535));
		write_register(REG_UNUSED, $urandom_range(0, 65535));
		queue_scans(180);

		// back to the reset values
		apply_setting(RST_RIGHT_BASE, RST_LEFT_BASE, RST_FRONT_LIMIT);
		queue_scans(180);

		wait_drained();
		repeat (8) @(posedge clk);
		mismatch_count += expected_verdicts.size();
		$display("covered %0d samples and %0d scan verdicts (%0d blocked) over %0d register settings",
			samples_taken, scans_checked, blocked_scans, settings_used);
		if (mismatch_count == 0) begin
			$display("laser_scan_obstacle_turn_decider_unit test passed");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("laser_scan_obstacle_turn_decider_unit test failed");
		end
		$finish;
	end

endmodule
